// ----- sv/bmg_pkg.sv -----
// Package for the binned mean grid: field widths, opcodes, FSM states
// and the command/status bundles between controller and datapath.
// No dependencies.
package bmg_pkg;

   // Default grid shape and number formats
   localparam int GRID_W_DEF     = 64;
   localparam int GRID_H_DEF     = 64;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 24;

   // Fixed field widths of the stream and register ports
   localparam int COORD_BITS     = 18;
   localparam int IDX_BITS       = 8;
   localparam int MEAN_BITS      = 16;
   localparam int DENS_BITS      = 24;
   localparam int REQ_DATA_BITS  = 72;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Item kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR,
      ST_RD_CHK,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture the item and read its cell
      logic add_write;  // write back the updated cell
      logic clr_write;  // zero one cell of the sweep and advance
      logic div_start;  // launch the mean division
      logic out_load;   // place the read result in the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;   // sweep is at the last cell
      logic found_ok;   // read cell is on grid and dense enough
      logic div_done;   // quotient ready
      logic out_free;   // output register can take a beat
   } status_type;

endpackage

// ----- sv/bmg_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module bmg_div #(
   parameter int N_BITS = 40,
   parameter int D_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [N_BITS-1:0] dividend,
   input  logic [D_BITS-1:0] divisor,
   output logic              done,
   output logic [N_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(N_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [D_BITS:0]     rem_ff, rem_in;
   logic [N_BITS-1:0]   quo_ff, quo_in;
   logic [D_BITS-1:0]   dvs_ff;
   logic [D_BITS:0]     rem_sh;
   logic [D_BITS+1:0]   diff;

   // One trial subtraction per step
   assign rem_sh = {rem_ff[D_BITS-1:0], quo_ff[N_BITS-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(N_BITS);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (diff[D_BITS+1]) begin
            rem_in = rem_sh;
            quo_in = {quo_ff[N_BITS-2:0], 1'b0};
         end else begin
            rem_in = diff[D_BITS:0];
            quo_in = {quo_ff[N_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Hold the divisor, shift remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff <= divisor;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/bmg_dpath.sv -----
// Datapath of the binned mean grid: cell address, cell memory, clear sweep,
// mean division and output register. Uses bmg_pkg and bmg_div.
module bmg_dpath
   import bmg_pkg::*;
#(
   parameter int GRID_W     = GRID_W_DEF,
   parameter int GRID_H     = GRID_H_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [1:0]               req_tuser,
   input  logic [DENS_BITS-1:0]     min_density,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [MEAN_BITS-1:0]     rsp_tdata,
   output logic                     rsp_tuser
);

   localparam int CELLS     = GRID_W * GRID_H;
   localparam int X_BITS    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int Y_BITS    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int CELL_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int VAL_BITS  = (FRAC_BITS < COORD_BITS - 1) ? FRAC_BITS : COORD_BITS - 1;
   localparam int SUM_BITS  = VAL_BITS + COUNT_BITS;
   localparam int MEM_BITS  = SUM_BITS + COUNT_BITS;
   localparam int PROD_BITS = COORD_BITS - 1 + 9;
   localparam int WIDE_BITS = SUM_BITS + MEAN_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COORD_BITS-1:0] h_coord, v_coord, sample_value;
   logic [IDX_BITS-1:0]   read_x, read_y;
   logic                  h_ok, v_ok, a_ok, grid_ok;
   logic [PROD_BITS-1:0]  prod_h, prod_v;
   logic [X_BITS-1:0]     cx;
   logic [Y_BITS-1:0]     cy;
   logic [CELL_BITS-1:0]  pos_add, pos_read, pos_sel;

   logic [CELL_BITS-1:0]  addr_ff;
   logic [VAL_BITS-1:0]   val_ff;
   logic                  ok_ff;
   logic [MEM_BITS-1:0]   mem_q_ff;
   logic [CELL_BITS-1:0]  clr_ff, clr_in;

   logic [SUM_BITS-1:0]   cur_sum;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic                  mem_we;
   logic [CELL_BITS-1:0]  mem_wa;
   logic [MEM_BITS-1:0]   mem_wd;

   logic [SUM_BITS-1:0]   quo;
   logic                  div_done;
   logic [WIDE_BITS-1:0]  mean_wide;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MEAN_BITS-1:0]  mean_ff;
   logic                  found_ff;

   logic [MEM_BITS-1:0]   mem [CELLS];

   // Unpack the item
   assign h_coord      = req_tdata[17:0];
   assign v_coord      = req_tdata[35:18];
   assign sample_value = req_tdata[53:36];
   assign read_x       = req_tdata[61:54];
   assign read_y       = req_tdata[69:62];

   // Sample must lie in [0,1)
   assign h_ok = !h_coord[COORD_BITS-1] && ((h_coord[COORD_BITS-2:0] >> FRAC_BITS) == '0);
   assign v_ok = !v_coord[COORD_BITS-1] && ((v_coord[COORD_BITS-2:0] >> FRAC_BITS) == '0);
   assign a_ok = !sample_value[COORD_BITS-1]
                 && ((sample_value[COORD_BITS-2:0] >> FRAC_BITS) == '0);

   // Cell of a sample: top bits of the scaled coordinates
   assign prod_h  = PROD_BITS'(h_coord[COORD_BITS-2:0]) * PROD_BITS'(GRID_W);
   assign prod_v  = PROD_BITS'(v_coord[COORD_BITS-2:0]) * PROD_BITS'(GRID_H);
   assign cx      = X_BITS'(prod_h >> FRAC_BITS);
   assign cy      = Y_BITS'(prod_v >> FRAC_BITS);
   assign pos_add = CELL_BITS'(32'(cy) * 32'(GRID_W) + 32'(cx));

   // Cell of a read request, with grid bounds
   assign grid_ok  = !read_x[IDX_BITS-1] && !read_y[IDX_BITS-1]
                     && ({1'b0, read_x} < 9'(GRID_W)) && ({1'b0, read_y} < 9'(GRID_H));
   assign pos_read = CELL_BITS'(32'(read_y) * 32'(GRID_W) + 32'(read_x));

   assign pos_sel = (opcode_type'(req_tuser) == OP_READ) ? pos_read : pos_add;

   // Capture the item and fetch its cell
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff  <= pos_sel;
         val_ff   <= sample_value[VAL_BITS-1:0];
         ok_ff    <= (opcode_type'(req_tuser) == OP_READ) ? grid_ok : (h_ok && v_ok && a_ok);
         mem_q_ff <= mem[pos_sel];
      end
   end

   assign cur_sum = mem_q_ff[MEM_BITS-1:COUNT_BITS];
   assign cur_cnt = mem_q_ff[COUNT_BITS-1:0];

   // Write port: sweep zeros or the updated cell
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = {cur_sum + SUM_BITS'(val_ff), cur_cnt + 1'b1};
      if (cmd.clr_write) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else if (cmd.add_write) begin
         mem_we = ok_ff && (cur_cnt != COUNT_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   // Advance the clear sweep, wrap to zero after the last cell
   assign clr_in = (clr_ff == CELL_BITS'(CELLS - 1)) ? '0 : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= clr_in;
      end
   end

   // Mean of the read cell
   bmg_div #(
      .N_BITS (SUM_BITS),
      .D_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cur_sum),
      .divisor  (cur_cnt),
      .done     (div_done),
      .quotient (quo)
   );

   // Rescale the quotient to 16 fraction bits
   assign mean_wide = (WIDE_BITS'(quo) << MEAN_BITS) >> FRAC_BITS;

   // Output register
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         found_ff <= status.found_ok;
         mean_ff  <= status.found_ok ? mean_wide[MEAN_BITS-1:0] : '0;
      end
   end

   assign status.clr_last = (clr_ff == CELL_BITS'(CELLS - 1));
   assign status.found_ok = ok_ff && (cur_cnt != '0)
                            && (32'(cur_cnt) >= 32'(min_density));
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mean_ff;
   assign rsp_tuser  = found_ff;

endmodule

// ----- sv/bmg_ctrl.sv -----
// Controller of the binned mean grid: sequences clear sweeps, cell updates
// and reads. Uses bmg_pkg; drives the datapath through cmd_type.
module bmg_ctrl
   import bmg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (opcode_type'(req_tuser))
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD:   state_in = ST_ADD_WR;
                  OP_READ:  state_in = ST_RD_CHK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_WR: state_in = ST_IDLE;
         ST_RD_CHK: state_in = status.found_ok ? ST_DIV : ST_DONE;
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_CLEAR:  cmd.clr_write = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_ADD_WR: cmd.add_write = 1'b1;
         ST_RD_CHK: cmd.div_start = status.found_ok;
         ST_DONE:   cmd.out_load  = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

// ----- sv/binned_mean_grid_2d.sv -----
// Top level of the binned mean grid: register port, controller, datapath.
// Uses bmg_pkg, bmg_ctrl and bmg_dpath.
//
// A grid of GRID_W x GRID_H cells gathering per-cell sums and counts.
// req_ beats carry an opcode on req_tuser: clear all cells, add a sample
// (coordinates and value in signed Q2.16, dropped unless all lie in [0,1)),
// or read a cell. Only a read gives an rsp_ beat: the truncated mean in
// Q0.16 on rsp_tdata and the found flag on rsp_tuser.
// An add reads the cell, then writes back its sum and count. A found read
// divides the cell's sum (SUM_BITS = 40 by default) by its count in the
// one-bit-per-cycle divider before loading the output register; a not-found
// read skips the division. A clear sweeps the memory one cell a cycle.
// After reset the same sweep runs with req_tready low; min_density returns
// to 1. Register writes are taken at any time.
// The result sits in an output register: while rsp_tready is low, clears
// and adds still proceed, and only a further read waits for the slot.
module binned_mean_grid_2d
   import bmg_pkg::*;
#(
   parameter int GRID_W     = GRID_W_DEF,
   parameter int GRID_H     = GRID_H_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // tdata: h_coord[17:0], v_coord[35:18], sample_value[53:36],
   //        read_x[61:54], read_y[69:62], zero fill [71:70]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata: mean_value[15:0]
   output logic [MEAN_BITS-1:0]     rsp_tdata,
   // tuser: found[0]
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [DENS_BITS-1:0] min_density_ff;
   logic                 csr_wr;
   cmd_type              cmd;
   status_type           status;

   // Register port: min_density at byte address 0
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_density_ff <= DENS_BITS'(1);
      end else if (csr_wr && !csr_paddr[2]) begin
         min_density_ff <= csr_pwdata[DENS_BITS-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DATA_BITS'(min_density_ff);

   bmg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   bmg_dpath #(
      .GRID_W     (GRID_W),
      .GRID_H     (GRID_H),
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .min_density (min_density_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
